>>> hw/rtl/tdpt_pkg.sv
// Shared constants and types for the trial-division prime tester.
`timescale 1ns / 1ps

package tdpt_pkg;

   // Width of the tested value.
   localparam int unsigned VALUE_WIDTH = 14;

   // Trial divisor width: holds floor(sqrt(max value)) + 1.
   localparam int unsigned DIV_W = (VALUE_WIDTH + 1) / 2 + 1;

   // Width of the running divisor square.
   localparam int unsigned SQ_W = VALUE_WIDTH + 2;

   // Bit counter of the remainder unit.
   localparam int unsigned CNT_W = (VALUE_WIDTH > 2) ? $clog2(VALUE_WIDTH) : 1;

   // Command from the sequencer to the remainder unit.
   typedef struct packed {
      logic start;
   } mod_ctl_type;

   // Status from the remainder unit back to the sequencer.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_sts_type;

endpackage

>>> hw/rtl/tdpt_if.sv
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface tdpt_req_if;
   logic                               valid;
   logic                               ready;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]   tested_value;
   logic                               is_prime;

   modport source (output valid, output tested_value, output is_prime, input ready);
   modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

>>> hw/rtl/tdpt_mod_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module tdpt_mod_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  tdpt_pkg::mod_ctl_type             ctl,
   input  logic [tdpt_pkg::VALUE_WIDTH-1:0]  dividend,
   input  logic [tdpt_pkg::DIV_W-1:0]        divisor,
   output tdpt_pkg::mod_sts_type             sts
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [tdpt_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [tdpt_pkg::DIV_W-1:0]        rem_ff, rem_in;
   logic [tdpt_pkg::DIV_W:0]          trial;

   // Shift in the next dividend bit and compare against the divisor
   assign trial = {rem_ff, dvd_ff[tdpt_pkg::VALUE_WIDTH-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (ctl.start) begin
         // Load a new operand and clear the partial remainder
         busy_in = 1'b1;
         cnt_in  = tdpt_pkg::CNT_W'(tdpt_pkg::VALUE_WIDTH - 1);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // Restore or subtract, then advance one bit
         if (trial >= {1'b0, divisor}) begin
            rem_in = tdpt_pkg::DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[tdpt_pkg::DIV_W-1:0];
         end
         dvd_in = {dvd_ff[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign sts.done     = done_ff;
   assign sts.rem_zero = (rem_ff == '0);

endmodule

>>> hw/rtl/trial_division_prime_test.sv
// Top level: sequencer that walks trial divisors through the shared remainder unit.
//
//   channel   dir   word fields                 handshake
//   req_chan  in    value                       valid / ready
//   rsp_chan  out   tested_value, is_prime      valid / ready
//
// Divisors run from 2 up to floor(sqrt(value)), stopping at the first hit; at 14 bits
// the worst case is the prime 16381, which tries every divisor from 2 to 127.
// The bit-serial remainder unit works through one dividend bit per cycle.
// Synchronous reset clears the sequencer, the output valid and the remainder unit's
// busy and done flags; nothing else needs it.
// req_chan.ready is high only while idle; a finished result waits in the output
// register, and a new word is taken as soon as the sequencer returns to idle.
`timescale 1ns / 1ps

module trial_division_prime_test (
   input  logic          clock,
   input  logic          reset,
   tdpt_req_if.sink      req_chan,
   tdpt_rsp_if.source    rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TEST   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]  n_ff, n_in;
   logic [tdpt_pkg::DIV_W-1:0]        d_ff, d_in;
   logic [tdpt_pkg::SQ_W-1:0]         sq_ff, sq_in;
   logic                              prime_ff, prime_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic                              rsp_prime_ff, rsp_prime_in;

   tdpt_pkg::mod_ctl_type             mod_ctl;
   tdpt_pkg::mod_sts_type             mod_sts;
   logic                              req_fire;
   logic                              out_free;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   tdpt_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mod_ctl),
      .dividend (n_ff),
      .divisor  (d_ff),
      .sts      (mod_sts)
   );

   // Sequencer: accept a word, test bound, run one remainder, step divisor, emit the verdict
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      prime_in      = prime_ff;
      mod_ctl.start = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_prime_in  = rsp_prime_ff;

      // Drop the output word once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in     = req_chan.value;
               d_in     = tdpt_pkg::DIV_W'(2);
               sq_in    = tdpt_pkg::SQ_W'(4);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (n_ff < tdpt_pkg::VALUE_WIDTH'(2)) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else if (sq_ff > tdpt_pkg::SQ_W'(n_ff)) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               mod_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_sts.done) begin
               if (mod_sts.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + tdpt_pkg::SQ_W'({d_ff, 1'b1});
                  d_in     = d_ff + 1'b1;
                  state_in = ST_TEST;
               end
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = n_ff;
               rsp_prime_in = prime_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      prime_ff     <= prime_in;
      rsp_value_ff <= rsp_value_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tested_value = rsp_value_ff;
   assign rsp_chan.is_prime     = rsp_prime_ff;

endmodule

>>> hw/rtl/tdpt_checker.sv
// Port-level checker for the prime tester, bound to the top level.
`timescale 1ns / 1ps

module tdpt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tdpt_pkg::VALUE_WIDTH-1:0]  rsp_tested_value,
   input logic                              rsp_is_prime
);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // Stop taking words once one is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in work");

   // Zero and one are never prime
   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tested_value == tdpt_pkg::VALUE_WIDTH'(0) ||
                    rsp_tested_value == tdpt_pkg::VALUE_WIDTH'(1)) |-> !rsp_is_prime)
      else $error("zero or one reported prime");

   // Even values above two are never prime
   a_even_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime && (rsp_tested_value > tdpt_pkg::VALUE_WIDTH'(2))
      |-> rsp_tested_value[0])
      else $error("even value above two reported prime");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_tested_value (rsp_chan.tested_value),
   .rsp_is_prime     (rsp_chan.is_prime)
);

>>> tb/tb.sv
// Testbench for the trial-division prime tester: directed table, random words, scoreboard.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CLOCK_HALF_NS = 4;
   localparam int unsigned RESET_CYCLES = 7;
   // Wait after the last expected verdict, long enough for the worst single word, with margin.
   localparam int unsigned DRAIN_CYCLES = 2500;
   localparam int unsigned RANDOM_PER_PHASE = 100;
   localparam int unsigned PRESSURE_WORDS = 12;
   localparam int unsigned PRESSURE_HOLD_CYCLES = 600;
   localparam int unsigned MAX_REPORTS = 10;
   // Budget for the 320 words at an 8 ns clock, taken several times over what they need.
   localparam int unsigned RUN_LIMIT_NS = 25_000_000;
   localparam int unsigned N_PROBES = 20;

   typedef logic [tdpt_pkg::VALUE_WIDTH-1:0] value_type;

   // One verdict as it should leave the block.
   typedef struct packed {
      value_type tested_value;
      logic      is_prime;
   } verdict_type;

   // One directed row; known marks a verdict typed in by hand.
   typedef struct packed {
      value_type value;
      logic      known;
      logic      prime;
   } probe_row_type;

   localparam probe_row_type PROBES [N_PROBES] = '{
      '{value_type'(0),     1'b1, 1'b0},   // zero: every candidate divides it
      '{value_type'(1),     1'b1, 1'b0},   // one: a single divisor
      '{value_type'(2),     1'b1, 1'b1},   // smallest prime
      '{value_type'(3),     1'b1, 1'b1},
      '{value_type'(4),     1'b1, 1'b0},
      '{value_type'(5),     1'b0, 1'b0},
      '{value_type'(8192),  1'b1, 1'b0},   // top bit alone
      '{value_type'(16383), 1'b1, 1'b0},   // all ones, divisible by three
      '{value_type'(16382), 1'b1, 1'b0},
      '{value_type'(16381), 1'b0, 1'b0},   // largest prime in range, longest search
      '{value_type'(16129), 1'b0, 1'b0},   // square of the last trial divisor
      '{value_type'(16127), 1'b0, 1'b0},
      '{value_type'(121),   1'b0, 1'b0},
      '{value_type'(49),    1'b0, 1'b0},
      '{value_type'(25),    1'b0, 1'b0},
      '{value_type'(9),     1'b0, 1'b0},
      '{value_type'(97),    1'b0, 1'b0},
      '{value_type'(10922), 1'b1, 1'b0},   // alternating bits, even
      '{value_type'(5461),  1'b0, 1'b0},   // alternating bits, odd
      '{value_type'(127),   1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   tdpt_req_if req_chan ();
   tdpt_rsp_if rsp_chan ();

   trial_division_prime_test dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   verdict_type pending_verdicts [$];
   int unsigned send_idle_pct = 25;
   int unsigned rsp_idle_pct = 74;
   int unsigned rsp_hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned verdicts_checked = 0;
   int unsigned primes_seen = 0;
   int unsigned input_stall_cycles = 0;

   // Prime when the value has exactly two divisors; search stops at the square root.
   function automatic logic prime_by_division(input value_type n);
      int unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Mix full-range values with small ones, values near the top and perfect squares.
   function automatic value_type draw_value();
      int unsigned d;
      case ($urandom_range(0, 9)) inside
         [0:5]: draw_value = value_type'($urandom_range(0, (1 << tdpt_pkg::VALUE_WIDTH) - 1));
         [6:7]: draw_value = value_type'($urandom_range(0, 255));
         8: draw_value = value_type'($urandom_range((1 << tdpt_pkg::VALUE_WIDTH) - 400,
                                                    (1 << tdpt_pkg::VALUE_WIDTH) - 1));
         default: begin
            d = $urandom_range(2, 127);
            draw_value = value_type'(d * d);
         end
      endcase
   endfunction

   // Offer one word after random idle cycles; queue its verdict once it is taken.
   task automatic offer_word(input value_type v, input logic known, input logic prime);
      bit skip;
      do begin
         @(negedge clock);
         skip = ($urandom_range(0, 99) < send_idle_pct);
         if (skip) req_chan.valid <= 1'b0;
      end while (skip);
      req_chan.valid <= 1'b1;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
      pending_verdicts.push_back(verdict_type'{tested_value: v,
                                 is_prime: known ? prime : prime_by_division(v)});
      words_sent++;
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Hard stop if the block hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout with %0d verdicts outstanding", pending_verdicts.size());
      $display("Test completed with failures");
      $finish;
   end

   // Drive response ready: a requested hold-off first, otherwise random idling.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Check each accepted verdict against the oldest one queued, and count input stall cycles.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (req_chan.valid && !req_chan.ready) input_stall_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            verdicts_checked++;
            if (rsp_chan.is_prime === 1'b1) primes_seen++;
            if (pending_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%t: unexpected verdict value=%0d is_prime=%0b", $realtime,
                           rsp_chan.tested_value, rsp_chan.is_prime);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_chan.tested_value !== want.tested_value ||
                   rsp_chan.is_prime !== want.is_prime) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"%t: verdict mismatch: expected value=%0d is_prime=%0b,",
                               " got value=%0d is_prime=%0b"},
                              $realtime, want.tested_value, want.is_prime,
                              rsp_chan.tested_value, rsp_chan.is_prime);
               end
            end
         end
      end
   end

   // Main sequence: reset, directed table, then three random phases.
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table with slow receiver.
      for (int i = 0; i < N_PROBES; i++)
         offer_word(PROBES[i].value, PROBES[i].known, PROBES[i].prime);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) offer_word(draw_value(), 1'b0, 1'b0);

      // Slow sender, mostly ready receiver.
      send_idle_pct = 74;
      rsp_idle_pct = 25;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) offer_word(draw_value(), 1'b0, 1'b0);

      // No idling; hold the receiver off while small words back the block up.
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_left = PRESSURE_HOLD_CYCLES;
      for (int i = 0; i < PRESSURE_WORDS; i++)
         offer_word(value_type'($urandom_range(0, 63)), 1'b0, 1'b0);
      for (int i = PRESSURE_WORDS; i < RANDOM_PER_PHASE; i++)
         offer_word(draw_value(), 1'b0, 1'b0);
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain, then give the block time to show any stray verdict.
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words and checked %0d verdicts, %0d of them prime.",
               words_sent, verdicts_checked, primes_seen);
      $display("Input stalled for %0d cycles; %0d verdict errors.",
               input_stall_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_if.sv
hw/rtl/tdpt_mod_unit.sv
hw/rtl/trial_division_prime_test.sv
hw/rtl/tdpt_checker.sv
tb/tb.sv
